// ===== design/positional_list_engine_defines.svh =====
// Assertion macros for the positional list engine.
`ifndef POSITIONAL_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
`define PLE_CHECK(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("positional list engine check failed");
`define PLE_CHECK_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("positional list engine check failed");
`else
`define PLE_CHECK(label, prop)
`define PLE_CHECK_NEXT(label, cond, prop)
`endif

`endif

// ===== design/ple_pkg.sv =====
package ple_pkg;

   localparam int DEPTH  = 16;
   localparam int VAL_W  = 32;
   localparam int POS_W  = 5;
   localparam int REQ_W  = 3;
   localparam int STAT_W = 3;
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int OCC_W  = $clog2(DEPTH + 1);
   localparam int CMP_W  = ((OCC_W > POS_W) ? OCC_W : POS_W) + 1;
   localparam int REQ_DATA_W = ((POS_W + VAL_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((VAL_W + POS_W + 7) / 8) * 8;

   typedef enum logic [REQ_W-1:0] {
      REQ_APPEND     = 3'd0,
      REQ_INSERT_AT  = 3'd1,
      REQ_DEL_FIRST  = 3'd2,
      REQ_DEL_LAST   = 3'd3,
      REQ_DEL_AT     = 3'd4,
      REQ_SEARCH     = 3'd5,
      REQ_READ_ALL   = 3'd6
   } ple_req_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_BADPOS   = 3'd3,
      ST_NOTFOUND = 3'd4
   } ple_status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_ROTATE
   } ple_cell_op_type;

   // Broadcast to every cell of the chain.
   typedef struct packed {
      ple_cell_op_type   op;
      logic [IDX_W-1:0]  index;
      logic [VAL_W-1:0]  value;
   } ple_cell_cmd_type;

   typedef struct packed {
      logic [VAL_W-1:0]  head;
      logic [VAL_W-1:0]  sel;
      logic [DEPTH-1:0]  match;
   } ple_chain_stat_type;

endpackage

// ===== design/ple_cell.sv =====
module ple_cell (
   input  logic                          clock,
   input  ple_pkg::ple_cell_cmd_type     cmd,
   input  logic [ple_pkg::IDX_W-1:0]     cell_index,
   input  logic [ple_pkg::VAL_W-1:0]     left_data,
   input  logic [ple_pkg::VAL_W-1:0]     right_data,
   input  logic [ple_pkg::VAL_W-1:0]     head_data,
   output logic [ple_pkg::VAL_W-1:0]     data_out,
   output logic                          match
);

   logic [ple_pkg::VAL_W-1:0] data_ff;
   logic [ple_pkg::VAL_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (cmd.op)
         ple_pkg::CELL_INSERT: begin
            // open a gap at the index, push the rest toward the tail
            if (cell_index == cmd.index) begin
               data_in = cmd.value;
            end else if (cell_index > cmd.index) begin
               data_in = left_data;
            end
         end
         ple_pkg::CELL_DELETE: begin
            if (cell_index >= cmd.index) begin
               data_in = right_data;
            end
         end
         ple_pkg::CELL_ROTATE: begin
            // head wraps around to the tail cell
            if (cell_index == cmd.index) begin
               data_in = head_data;
            end else if (cell_index < cmd.index) begin
               data_in = right_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;
   assign match    = (data_ff == cmd.value);

endmodule

// ===== design/ple_chain.sv =====
module ple_chain (
   input  logic                          clock,
   input  ple_pkg::ple_cell_cmd_type     cmd,
   output ple_pkg::ple_chain_stat_type   stat
);

   localparam int DEPTH = ple_pkg::DEPTH;
   localparam int IDX_W = ple_pkg::IDX_W;
   localparam int VAL_W = ple_pkg::VAL_W;

   logic [VAL_W-1:0] data_w  [DEPTH];
   logic [VAL_W-1:0] left_w  [DEPTH];
   logic [VAL_W-1:0] right_w [DEPTH];
   logic [DEPTH-1:0] match_w;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_first
         assign left_w[g] = '0;
      end else begin : g_mid
         assign left_w[g] = data_w[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign right_w[g] = '0;
      end else begin : g_inner
         assign right_w[g] = data_w[g+1];
      end

      ple_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .cell_index (IDX_W'(g)),
         .left_data  (left_w[g]),
         .right_data (right_w[g]),
         .head_data  (data_w[0]),
         .data_out   (data_w[g]),
         .match      (match_w[g])
      );
   end

   assign stat.head  = data_w[0];
   assign stat.sel   = data_w[cmd.index];
   assign stat.match = match_w;

endmodule

// ===== design/positional_list_engine.sv =====
// Append, insert, delete, an empty read all and unused codes register their result word from ST_EXEC;
// search goes on to ST_FIND, which uses the registered match vector, and read all goes on to ST_READ.
// Throughput: append, insert and delete accept one word per cycle while rsp_tready stays high;
// a search or a read all accepts no new request word until its last response word is loaded.
// Read all streams one word per cycle from the head as the cell chain rotates, while rsp_tready stays high.
// Reset: occupancy clears to zero, no response pending; cell contents are not cleared.
`include "positional_list_engine_defines.svh"

module positional_list_engine (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [4:0] position, [36:5] value, [39:37] zero
   input  logic [ple_pkg::REQ_DATA_W-1:0]       req_tdata,
   // [2:0] req_type
   input  logic [ple_pkg::REQ_W-1:0]            req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [31:0] result_value, [36:32] result_position, [39:37] zero
   output logic [ple_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // [2:0] status
   output logic [ple_pkg::STAT_W-1:0]           rsp_tuser,
   // last
   output logic                                 rsp_tlast
);

   localparam int DEPTH  = ple_pkg::DEPTH;
   localparam int VAL_W  = ple_pkg::VAL_W;
   localparam int POS_W  = ple_pkg::POS_W;
   localparam int IDX_W  = ple_pkg::IDX_W;
   localparam int OCC_W  = ple_pkg::OCC_W;
   localparam int CMP_W  = ple_pkg::CMP_W;
   localparam int RSP_DATA_W = ple_pkg::RSP_DATA_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FIND,
      ST_READ
   } state_type;

   state_type                   state_ff, state_in;
   logic [OCC_W-1:0]            occ_ff, occ_in;
   logic [IDX_W-1:0]            rd_cnt_ff, rd_cnt_in;
   logic                        rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0]       rsp_tdata_ff;
   logic [ple_pkg::STAT_W-1:0]  rsp_tuser_ff;
   logic                        rsp_tlast_ff;
   ple_pkg::ple_req_type        req_op_ff;
   logic [POS_W-1:0]            req_pos_ff;
   logic [VAL_W-1:0]            req_val_ff;
   logic [DEPTH-1:0]            match_ff, match_in;

   ple_pkg::ple_cell_cmd_type   cmd;
   ple_pkg::ple_chain_stat_type stat;

   logic                        slot_free;
   logic                        capture;
   logic                        rsp_load;
   ple_pkg::ple_status_type     rsp_status;
   logic [VAL_W-1:0]            rsp_value;
   logic [POS_W-1:0]            rsp_pos;
   logic                        rsp_last;
   logic [CMP_W-1:0]            occ_ext;
   logic [CMP_W-1:0]            pos_ext;
   logic [CMP_W-1:0]            pos_m1;
   logic [CMP_W-1:0]            tail_ext;
   logic [CMP_W-1:0]            next_pos;
   logic                        found;
   logic [CMP_W-1:0]            found_pos;
   logic                        is_full;
   logic                        is_empty;

   ple_chain u_chain (
      .clock (clock),
      .cmd   (cmd),
      .stat  (stat)
   );

   assign slot_free = !rsp_tvalid_ff || rsp_tready;
   assign capture   = req_tvalid && req_tready;
   assign occ_ext   = CMP_W'(occ_ff);
   assign pos_ext   = CMP_W'(req_pos_ff);
   assign pos_m1    = pos_ext - CMP_W'(1);
   assign tail_ext  = occ_ext - CMP_W'(1);
   assign next_pos  = CMP_W'(rd_cnt_ff) + CMP_W'(1);
   assign is_full   = (occ_ext == CMP_W'(DEPTH));
   assign is_empty  = (occ_ff == '0);

   // first match from the head
   always_comb begin
      found     = 1'b0;
      found_pos = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            found     = 1'b1;
            found_pos = CMP_W'(i + 1);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         match_in[i] = stat.match[i] && (CMP_W'(i) < occ_ext);
      end
   end

   always_comb begin
      state_in      = state_ff;
      occ_in        = occ_ff;
      rd_cnt_in     = rd_cnt_ff;
      req_tready    = 1'b0;
      rsp_load      = 1'b0;
      rsp_status    = ple_pkg::ST_OK;
      rsp_value     = '0;
      rsp_pos       = '0;
      rsp_last      = 1'b1;
      cmd.op        = ple_pkg::CELL_HOLD;
      cmd.index     = '0;
      cmd.value     = req_val_ff;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (req_op_ff == ple_pkg::REQ_SEARCH) begin
               state_in = ST_FIND;
            end else if (req_op_ff == ple_pkg::REQ_READ_ALL && !is_empty) begin
               state_in  = ST_READ;
               rd_cnt_in = '0;
            end else if (slot_free) begin
               rsp_load   = 1'b1;
               req_tready = 1'b1;
               state_in   = req_tvalid ? ST_EXEC : ST_IDLE;
               case (req_op_ff)
                  ple_pkg::REQ_APPEND: begin
                     if (is_full) begin
                        rsp_status = ple_pkg::ST_FULL;
                     end else begin
                        cmd.op    = ple_pkg::CELL_INSERT;
                        cmd.index = occ_ext[IDX_W-1:0];
                        occ_in    = occ_ff + OCC_W'(1);
                     end
                  end
                  ple_pkg::REQ_INSERT_AT: begin
                     if (is_full) begin
                        rsp_status = ple_pkg::ST_FULL;
                     end else if (pos_ext == '0 || pos_ext > occ_ext + CMP_W'(1)) begin
                        rsp_status = ple_pkg::ST_BADPOS;
                     end else begin
                        cmd.op    = ple_pkg::CELL_INSERT;
                        cmd.index = pos_m1[IDX_W-1:0];
                        occ_in    = occ_ff + OCC_W'(1);
                     end
                  end
                  ple_pkg::REQ_DEL_FIRST,
                  ple_pkg::REQ_DEL_LAST: begin
                     if (is_empty) begin
                        rsp_status = ple_pkg::ST_EMPTY;
                     end else begin
                        cmd.op    = ple_pkg::CELL_DELETE;
                        cmd.index = (req_op_ff == ple_pkg::REQ_DEL_FIRST) ?
                                    '0 : tail_ext[IDX_W-1:0];
                        rsp_value = stat.sel;
                        occ_in    = occ_ff - OCC_W'(1);
                     end
                  end
                  ple_pkg::REQ_DEL_AT: begin
                     if (is_empty) begin
                        rsp_status = ple_pkg::ST_EMPTY;
                     end else if (pos_ext == '0 || pos_ext > occ_ext) begin
                        rsp_status = ple_pkg::ST_BADPOS;
                     end else begin
                        cmd.op    = ple_pkg::CELL_DELETE;
                        cmd.index = pos_m1[IDX_W-1:0];
                        rsp_value = stat.sel;
                        occ_in    = occ_ff - OCC_W'(1);
                     end
                  end
                  ple_pkg::REQ_READ_ALL: begin
                     rsp_status = ple_pkg::ST_EMPTY;
                  end
                  default: begin
                     rsp_status = ple_pkg::ST_OK;
                  end
               endcase
            end
         end
         ST_FIND: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
               if (found) begin
                  rsp_value = req_val_ff;
                  rsp_pos   = found_pos[POS_W-1:0];
               end else begin
                  rsp_status = ple_pkg::ST_NOTFOUND;
               end
            end
         end
         ST_READ: begin
            if (slot_free) begin
               // emit the head, then rotate it behind the tail
               rsp_load  = 1'b1;
               rsp_value = stat.head;
               rsp_pos   = next_pos[POS_W-1:0];
               rsp_last  = (next_pos == occ_ext);
               cmd.op    = ple_pkg::CELL_ROTATE;
               cmd.index = tail_ext[IDX_W-1:0];
               rd_cnt_in = next_pos[IDX_W-1:0];
               if (rsp_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (rsp_load) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         occ_ff        <= '0;
         rd_cnt_ff     <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         occ_ff        <= occ_in;
         rd_cnt_ff     <= rd_cnt_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      if (capture) begin
         req_op_ff  <= ple_pkg::ple_req_type'(req_tuser);
         req_pos_ff <= req_tdata[POS_W-1:0];
         req_val_ff <= req_tdata[POS_W+VAL_W-1:POS_W];
      end
      if (rsp_load) begin
         rsp_tdata_ff <= RSP_DATA_W'({rsp_pos, rsp_value});
         rsp_tuser_ff <= rsp_status;
         rsp_tlast_ff <= rsp_last;
      end
      match_ff <= match_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   `PLE_CHECK(a_occ_bound, occ_ext <= CMP_W'(DEPTH))
   `PLE_CHECK_NEXT(a_occ_only_exec, state_ff != ST_EXEC, $stable(occ_ff))
   `PLE_CHECK(a_read_cnt_range, state_ff != ST_READ || CMP_W'(rd_cnt_ff) < occ_ext)
   `PLE_CHECK(a_error_is_last, !rsp_tvalid_ff || rsp_tuser_ff == ple_pkg::ST_OK || rsp_tlast_ff)

endmodule
